// File: design/rrbde_pkg.sv
// Package for the receive ring buffer with delimiter extraction.
// Holds ring geometry, field widths and command codes; no dependencies.
`default_nettype none

package rrbde_pkg;

  localparam int DEPTH       = 64;               // ring entries, holds DEPTH-1 bytes
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int MAX_PATTERN = 8;                // longest delimiter in bytes
  localparam int PIDX_W      = 3;                // index into the pattern bytes
  localparam int PLEN_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 64;
  localparam int CNT_W       = 6;                // width of count fields in a result
  localparam int KIND_W      = 2;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 24;
  localparam int OUT_USER_W  = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXTRACT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

  localparam logic [BYTE_W-1:0] POP_EMPTY_BYTE = 8'hFF;

endpackage

`default_nettype wire

// File: design/rx_ring_buffer_delimiter_extract.sv
// Receive byte ring buffer: push, pop, delimiter extract, flag clear. Uses rrbde_pkg.
// Push, clear and short results go through ST_RESP to the output register; a valid pop
// first reads its byte in ST_POP_RD. Extract scans through the single RAM read port,
// a read then a compare per byte, then emits the frame byte by byte (one read, one
// output load each). One item at a time: a new item is accepted only while idle.
// Reset (rst_n low, synchronous) empties the ring, clears flag and output valid.
`default_nettype none

module rx_ring_buffer_delimiter_extract
  import rrbde_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  // input channel
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_DATA_W-1:0]    in_tdata,   // byte_in[7:0], pattern[71:8], pattern_length[75:72]
  input  wire [KIND_W-1:0]       in_tuser,   // kind[1:0]
  // result channel
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // data_out[7:0], frame_length[13:8],
                                             // used_count[19:14], received_flag[20],
                                             // dropped_oldest[21]
  output logic [OUT_USER_W-1:0]  out_tuser,  // data_valid[0], found[1]
  output logic                   out_tlast
);

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RESP     = 3'd1;  // single-word result, waits for output slot
  localparam logic [2:0] ST_POP_RD   = 3'd2;  // pop read data arriving
  localparam logic [2:0] ST_SCAN_RD  = 3'd3;  // issue read of next scanned byte
  localparam logic [2:0] ST_SCAN_CHK = 3'd4;  // shift byte into window, compare
  localparam logic [2:0] ST_EMIT_RD  = 3'd5;  // issue read of next frame byte
  localparam logic [2:0] ST_EMIT_OUT = 3'd6;  // hand frame byte to output register

  // modular add on ring indices; n is below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] n);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + {1'b0, n};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // byte store
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic [IDX_W-1:0]  raddr;
  logic              rd_en;
  logic              wr_en;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic              rx_r, rx_nxt;
  logic              out_valid_r, out_valid_nxt;

  // item context
  logic [PAT_W-1:0]  pat_r, pat_nxt;
  logic [PLEN_W-1:0] plen_r, plen_nxt;
  logic [BYTE_W-1:0] res_data_r, res_data_nxt;
  logic              res_dv_r, res_dv_nxt;
  logic              drop_r, drop_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;      // scan position or emit index
  logic [IDX_W-1:0]  flen_r, flen_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;  // head before the frame was taken
  logic [BYTE_W-1:0] win_r   [MAX_PATTERN];
  logic [BYTE_W-1:0] win_nxt [MAX_PATTERN];

  // output register
  logic              load_out;
  logic [BYTE_W-1:0] o_data_r, o_data_nxt;
  logic              o_dv_r, o_dv_nxt;
  logic              o_last_r, o_last_nxt;
  logic              o_found_r, o_found_nxt;
  logic [IDX_W-1:0]  o_flen_r, o_flen_nxt;
  logic [IDX_W-1:0]  o_used_r, o_used_nxt;
  logic              o_flag_r, o_flag_nxt;
  logic              o_drop_r, o_drop_nxt;

  logic              in_acc;
  logic              out_free;
  logic [IDX_W-1:0]  used;
  logic [IDX_W-1:0]  used_new;            // count after the updates of this cycle
  logic [PLEN_W-1:0] in_plen_sat;
  logic              match;
  logic [IDX_W:0]    pos_p1;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // occupancy; ring need not be a power of two
  always_comb begin
    if (tail_r >= head_r) begin
      used = tail_r - head_r;
    end else begin
      used = IDX_W'({1'b0, tail_r} + (IDX_W+1)'(DEPTH) - {1'b0, head_r});
    end
    if (tail_nxt >= head_nxt) begin
      used_new = tail_nxt - head_nxt;
    end else begin
      used_new = IDX_W'({1'b0, tail_nxt} + (IDX_W+1)'(DEPTH) - {1'b0, head_nxt});
    end
  end

  // lengths above the maximum saturate
  always_comb begin
    if (in_tdata[75:72] > PLEN_W'(MAX_PATTERN)) begin
      in_plen_sat = PLEN_W'(MAX_PATTERN);
    end else begin
      in_plen_sat = in_tdata[75:72];
    end
  end

  // window with the byte now arriving; win_nxt[0] is the newest
  always_comb begin
    win_nxt = win_r;
    if (state_r == ST_SCAN_CHK) begin
      for (int j = MAX_PATTERN - 1; j > 0; j--) begin
        win_nxt[j] = win_r[j-1];
      end
      win_nxt[0] = rdata_r;
    end
  end

  // window position j holds pattern byte plen-1-j
  always_comb begin
    logic [PIDX_W-1:0] pidx;
    match = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = PIDX_W'(plen_r - PLEN_W'(j) - PLEN_W'(1));
      if (PLEN_W'(j) < plen_r) begin
        if (win_nxt[j] != pat_r[pidx*BYTE_W +: BYTE_W]) begin
          match = 1'b0;
        end
      end
    end
  end

  assign pos_p1 = {1'b0, cnt_r} + (IDX_W+1)'(1);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    rx_nxt       = rx_r;
    pat_nxt      = pat_r;
    plen_nxt     = plen_r;
    res_data_nxt = res_data_r;
    res_dv_nxt   = res_dv_r;
    drop_nxt     = drop_r;
    cnt_nxt      = cnt_r;
    flen_nxt     = flen_r;
    start_nxt    = start_r;
    rd_en        = 1'b0;
    raddr        = head_r;
    wr_en        = 1'b0;
    load_out     = 1'b0;
    o_data_nxt   = o_data_r;
    o_dv_nxt     = o_dv_r;
    o_last_nxt   = o_last_r;
    o_found_nxt  = o_found_r;
    o_flen_nxt   = o_flen_r;
    o_flag_nxt   = o_flag_r;
    o_drop_nxt   = o_drop_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pat_nxt      = in_tdata[71:8];
          plen_nxt     = in_plen_sat;
          res_data_nxt = '0;
          res_dv_nxt   = 1'b0;
          drop_nxt     = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = ST_RESP;
          case (in_tuser)
            KIND_PUSH: begin
              wr_en = 1'b1;
              if (used >= IDX_W'(DEPTH - 1)) begin
                head_nxt = ring_add(head_r, IDX_W'(1));
                drop_nxt = 1'b1;
              end
              tail_nxt = ring_add(tail_r, IDX_W'(1));
              rx_nxt   = 1'b1;
            end
            KIND_POP: begin
              if (used == '0) begin
                res_data_nxt = POP_EMPTY_BYTE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = ST_POP_RD;
              end
            end
            KIND_EXTRACT: begin
              // zero length or too little data: not found
              if (in_plen_sat != '0 && (IDX_W+1)'(in_plen_sat) <= {1'b0, used}) begin
                state_nxt = ST_SCAN_RD;
              end
            end
            KIND_CLEAR: begin
              rx_nxt = 1'b0;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_POP_RD: begin
        res_data_nxt = rdata_r;
        res_dv_nxt   = 1'b1;
        head_nxt     = ring_add(head_r, IDX_W'(1));
        state_nxt    = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          load_out    = 1'b1;
          o_data_nxt  = res_data_r;
          o_dv_nxt    = res_dv_r;
          o_last_nxt  = 1'b1;
          o_found_nxt = 1'b0;
          o_flen_nxt  = '0;
          o_flag_nxt  = rx_r;
          o_drop_nxt  = drop_r;
          state_nxt   = ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        rd_en     = 1'b1;
        raddr     = ring_add(head_r, cnt_r);
        state_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (match && pos_p1 >= (IDX_W+1)'(plen_r)) begin
          // earliest complete occurrence ends here
          flen_nxt  = pos_p1[IDX_W-1:0];
          start_nxt = head_r;
          head_nxt  = ring_add(head_r, pos_p1[IDX_W-1:0]);
          cnt_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end else if (pos_p1 == {1'b0, used}) begin
          state_nxt = ST_RESP;
        end else begin
          cnt_nxt   = pos_p1[IDX_W-1:0];
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        raddr     = ring_add(start_r, cnt_r);
        state_nxt = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (out_free) begin
          load_out    = 1'b1;
          o_data_nxt  = rdata_r;
          o_dv_nxt    = 1'b1;
          o_last_nxt  = (pos_p1 == {1'b0, flen_r});
          o_found_nxt = 1'b1;
          o_flen_nxt  = flen_r;
          o_flag_nxt  = rx_r;
          o_drop_nxt  = 1'b0;
          if (pos_p1 == {1'b0, flen_r}) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = pos_p1[IDX_W-1:0];
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    o_used_nxt = load_out ? used_new : o_used_r;

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= in_tdata[7:0];
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      rx_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      rx_r        <= rx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r      <= pat_nxt;
    plen_r     <= plen_nxt;
    res_data_r <= res_data_nxt;
    res_dv_r   <= res_dv_nxt;
    drop_r     <= drop_nxt;
    cnt_r      <= cnt_nxt;
    flen_r     <= flen_nxt;
    start_r    <= start_nxt;
    win_r      <= win_nxt;
    o_data_r   <= o_data_nxt;
    o_dv_r     <= o_dv_nxt;
    o_last_r   <= o_last_nxt;
    o_found_r  <= o_found_nxt;
    o_flen_r   <= o_flen_nxt;
    o_used_r   <= o_used_nxt;
    o_flag_r   <= o_flag_nxt;
    o_drop_r   <= o_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = {o_found_r, o_dv_r};
  assign out_tdata  = {2'b00, o_drop_r, o_flag_r, CNT_W'(o_used_r), CNT_W'(o_flen_r),
                       o_data_r};

endmodule

`default_nettype wire
